@@ hw/rtl/wbps_pkg.sv @@
// Shared constants and types of the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

  // Default number of pattern positions.
  localparam int PATTERN_BYTES_DEF = 16;

  // Fixed register widths.
  localparam int ADDR_W  = 64;
  localparam int BYTE_W  = 8;
  localparam int MAX_PAT = 16;
  localparam int LEN_W   = 5;
  localparam int IDX_W   = 4;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS   = 3'd0,
    REG_PATTERN_LOW    = 3'd1,
    REG_PATTERN_HIGH   = 3'd2,
    REG_WILDCARD_MASK  = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } wbps_reg_t;

  // Pattern settings as seen by every cell.
  typedef struct packed {
    logic [MAX_PAT*BYTE_W-1:0] pattern;
    logic [MAX_PAT-1:0]        mask;
    logic [LEN_W-1:0]          len;
  } wbps_cfg_t;

endpackage

@@ hw/rtl/wbps_cell.sv @@
// One cell of the history line: holds one past byte and checks it against its pattern position.
`timescale 1ns / 1ps

module wbps_cell
  import wbps_pkg::*;
#(
  parameter int AGE = 0
) (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [BYTE_W-1:0] byte_in,
  input  wbps_cfg_t         cfg,
  output logic [BYTE_W-1:0] byte_out,
  output logic              hit
);

  logic [BYTE_W-1:0] byte_r;
  logic [LEN_W-1:0]  pos_full;
  logic [IDX_W-1:0]  pos;
  logic              care;

  // The held byte moves on to the next cell on every accepted beat.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // This cell lines up with pattern position len-2-AGE when it lies inside the pattern.
  assign care     = ({1'b0, cfg.len} >= (LEN_W + 1)'(AGE + 2));
  assign pos_full = cfg.len - LEN_W'(AGE + 2);
  assign pos      = pos_full[IDX_W-1:0];

  assign hit = !care || cfg.mask[pos] ||
               (byte_r == cfg.pattern[pos*BYTE_W +: BYTE_W]);

endmodule

@@ hw/rtl/wildcard_byte_pattern_scanner_unit.sv @@
// Top level of the wildcard byte pattern scanner: registers, cell line, result register.
// A result is registered: it appears on the output in the cycle after the beat that causes it.
// Throughput: one byte per cycle unless stalled; all pattern positions are compared in parallel.
// Input is stalled only while a result waits in the output register and out_tready is low.
// Reset (rst_n low, synchronous) loads register defaults and clears the scan state and result valid.
// The scan state also clears after every beat that carries tlast.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_unit
  import wbps_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // region_end
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [63:0] match_address
  output logic [0:0]           out_tuser,  // [0] found
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int SEEN_W = $clog2(PATTERN_BYTES + 1);

  // Configuration registers.
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] pat_low_r;
  logic [ADDR_W-1:0] pat_high_r;
  logic [MAX_PAT-1:0] mask_r;
  logic [LEN_W-1:0]  len_r;

  // Scan state.
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [ADDR_W-1:0] offset_r, offset_nxt;
  logic              reported_r, reported_nxt;

  // Result register.
  logic              out_valid_r;
  logic              out_found_r;
  logic [ADDR_W-1:0] out_addr_r;

  wbps_cfg_t         cfg;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  len_m1;
  logic [IDX_W-1:0]  head_pos;
  logic [PATTERN_BYTES-1:0] pos_hit;
  logic [BYTE_W-1:0] link [PATTERN_BYTES];
  logic              in_beat;
  logic              enough;
  logic              hit_now;
  logic              found_now;
  logic              nf_now;
  logic [ADDR_W-1:0] addr_now;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
      mask_r     <= '0;
      len_r      <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS:   base_r     <= cfg_wdata;
        REG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        REG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        REG_WILDCARD_MASK:  mask_r     <= cfg_wdata[MAX_PAT-1:0];
        REG_PATTERN_LENGTH: len_r      <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Length in use: zero counts as one, anything past the cell line is clipped.
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(PATTERN_BYTES)) begin
      len_eff = LEN_W'(PATTERN_BYTES);
    end else begin
      len_eff = len_r;
    end
  end

  assign len_m1      = len_eff - LEN_W'(1);
  assign head_pos    = len_m1[IDX_W-1:0];
  assign cfg.pattern = {pat_high_r, pat_low_r};
  assign cfg.mask    = mask_r;
  assign cfg.len     = len_eff;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  // The incoming byte takes the last pattern position in use.
  assign pos_hit[PATTERN_BYTES-1] = cfg.mask[head_pos] ||
      (in_tdata == cfg.pattern[head_pos*BYTE_W +: BYTE_W]);

  // Line of history cells, newest byte in cell 0.
  assign link[0] = in_tdata;
  for (genvar i = 0; i < PATTERN_BYTES - 1; i++) begin : g_cell
    wbps_cell #(
      .AGE (i)
    ) u_cell (
      .clk      (clk),
      .shift_en (in_beat),
      .byte_in  (link[i]),
      .cfg      (cfg),
      .byte_out (link[i+1]),
      .hit      (pos_hit[i])
    );
  end

  // A match counts only once the region holds enough bytes.
  assign enough    = ((LEN_W + 1)'(seen_r) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(len_eff);
  assign hit_now   = !reported_r && enough && (&pos_hit);
  assign found_now = in_beat && hit_now;
  assign nf_now    = in_beat && in_tlast && !reported_r && !hit_now;
  assign addr_now  = base_r + (offset_r - ADDR_W'(len_m1));

  // Next scan state.
  always_comb begin
    seen_nxt     = seen_r;
    offset_nxt   = offset_r;
    reported_nxt = reported_r;
    if (in_beat) begin
      if (in_tlast) begin
        seen_nxt     = '0;
        offset_nxt   = '0;
        reported_nxt = 1'b0;
      end else begin
        if (seen_r < SEEN_W'(PATTERN_BYTES)) begin
          seen_nxt = seen_r + SEEN_W'(1);
        end
        offset_nxt = offset_r + ADDR_W'(1);
        if (hit_now) begin
          reported_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      offset_r   <= '0;
      reported_r <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      offset_r   <= offset_nxt;
      reported_r <= reported_nxt;
    end
  end

  // Result register: loads on a causing beat, empties when the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (found_now || nf_now) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (found_now) begin
      out_found_r <= 1'b1;
      out_addr_r  <= addr_now;
    end else if (nf_now) begin
      out_found_r <= 1'b0;
      out_addr_r  <= '0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_addr_r;
  assign out_tuser[0] = out_found_r;

`ifndef NO_ASSERTIONS
  // The last beat of a region leaves a clean scan state.
  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_tlast |=> seen_r == '0 && offset_r == '0 && !reported_r)
    else $error("scan state not cleared after region end");

  // A first match inside a region marks the region as reported.
  a_reported: assert property (@(posedge clk) disable iff (!rst_n)
    found_now && !in_tlast |=> reported_r)
    else $error("match not recorded");

  // A taken result with nothing new behind it empties the output.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !found_now && !nf_now |=> !out_tvalid)
    else $error("result beat repeated");

  // A reported match sets found in the result.
  a_found_flag: assert property (@(posedge clk) disable iff (!rst_n)
    found_now |=> out_tvalid && out_tuser[0])
    else $error("found result lost");
`endif

endmodule

@@ tb/tb_wildcard_byte_pattern_scanner_unit.sv @@
// Self-checking testbench for the wildcard byte pattern scanner top level.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_unit;
  import wbps_pkg::*;

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  // Cycles without any accepted beat before the run is abandoned.
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BYTES = 850;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  // Tracks the scan of each region and holds the results still to come.
  class match_tracker;
    logic [ADDR_W-1:0]        base_addr;
    logic [MAX_PAT*BYTE_W-1:0] pattern;
    logic [MAX_PAT-1:0]       wild_mask;
    logic [LEN_W-1:0]         len_field;
    logic [BYTE_W-1:0]        history [MAX_PAT-1];
    int                       held;
    logic [ADDR_W-1:0]        offset;
    bit                       reported;
    scan_result_t             pending_results [$];
    int                       errors;

    function new();
      base_addr = '0;
      pattern   = '0;
      wild_mask = '0;
      len_field = LEN_W'(1);
      errors    = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (history[k]) history[k] = '0;
      held     = 0;
      offset   = '0;
      reported = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      case (idx)
        REG_BASE_ADDRESS:   base_addr = value;
        REG_PATTERN_LOW:    pattern[63:0] = value;
        REG_PATTERN_HIGH:   pattern[127:64] = value;
        REG_WILDCARD_MASK:  wild_mask = value[MAX_PAT-1:0];
        REG_PATTERN_LENGTH: len_field = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Pattern bytes in use: zero counts as one, oversize values are clamped.
    function int span();
      int n;
      n = len_field;
      if (n == 0) n = 1;
      if (n > PATTERN_BYTES_DEF) n = PATTERN_BYTES_DEF;
      return n;
    endfunction

    function logic [BYTE_W-1:0] pattern_at(int j);
      return pattern[BYTE_W*j +: BYTE_W];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Appends one expected result at the tail of the queue.
    function void queue_result(scan_result_t res);
      pending_results = {pending_results, res};
    endfunction

    // Works out the result, if any, of one accepted input beat.
    function void note_byte(logic [BYTE_W-1:0] data, logic last);
      int           len;
      bit           hit;
      logic [7:0]   seen_byte;
      scan_result_t res;
      len = span();
      if (!reported && held + 1 >= len) begin
        hit = 1'b1;
        for (int j = 0; j < len; j++) begin
          if (j == len - 1) seen_byte = data;
          else seen_byte = history[len - 2 - j];
          if (!wild_mask[j] && seen_byte != pattern_at(j)) hit = 1'b0;
        end
        if (hit) begin
          res.found = 1'b1;
          res.addr  = base_addr + (offset - ADDR_W'(len - 1));
          queue_result(res);
          reported = 1'b1;
        end
      end
      if (last) begin
        if (!reported) begin
          res.found = 1'b0;
          res.addr  = '0;
          queue_result(res);
        end
        clear_scan();
        return;
      end
      for (int k = MAX_PAT - 2; k > 0; k--) history[k] = history[k-1];
      history[0] = data;
      if (held < PATTERN_BYTES_DEF) held++;
      offset++;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic found, logic [ADDR_W-1:0] addr);
      scan_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result found=%0d address=%h", found, addr));
        return;
      end
      want = pending_results.pop_front();
      if (found !== want.found)
        report($sformatf("found: got %0d, want %0d", found, want.found));
      if (addr !== want.addr)
        report($sformatf("match_address: got %h, want %h", addr, want.addr));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [63:0]          out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;

  match_tracker sb;
  int           beats_sent = 0;
  int           quiet_cycles = 0;
  bit           in_burst = 1'b0;
  bit           out_burst = 1'b0;

  wildcard_byte_pattern_scanner_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_wildcard_byte_pattern_scanner_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: waits a random number of cycles, then takes one beat.
  initial begin
    int wait_cycles;
    out_tready <= 1'b0;
    @(negedge clk);
    forever begin
      wait_cycles = out_burst ? 0 : $urandom_range(0, 4);
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tuser[0], out_tdata);
      @(negedge clk);
    end
  end

  // Entered and left at a falling edge; valid stays high for a following beat.
  task automatic send_beat(input logic [7:0] data, input logic last);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_byte(data, last);
    beats_sent++;
    @(negedge clk);
  endtask

  // Stops input and waits until every expected result has been taken.
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic program_scan(input logic [63:0] base, lo, hi, mask_word, len_word,
                              input bit spares);
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_WILDCARD_MASK, mask_word);
    write_reg(REG_PATTERN_LENGTH, len_word);
    if (spares)
      for (int i = REG_SPARE_FIRST; i < (1 << CFG_IDX_W); i++)
        write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // New settings for a phase; the first few phases take the extremes.
  task automatic pick_settings(input int phase);
    logic [63:0] base, lo, hi, mask_word, len_word;
    base = {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h3F : 8'($urandom);
      hi[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h3F : 8'($urandom);
    end
    mask_word = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: mask_word[15:0] = '0;
      1: mask_word[15:0] = 16'($urandom & $urandom & $urandom);
      default: ;
    endcase
    len_word = {$urandom, $urandom};
    len_word[4:0] = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 16));
    case (phase)
      0: begin
        base      = '0;
        mask_word = '0;
        len_word  = 64'd1;
      end
      1: begin
        base      = '1;
        mask_word = '1;
        len_word  = 64'd16;
      end
      2: len_word = 64'd31;
      3: len_word = '0;
      default: ;
    endcase
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    drain(4);
    program_scan(base, lo, hi, mask_word, len_word, $urandom_range(0, 1));
  endtask

  // One region of noise, near misses and, if asked, a planted match.
  task automatic send_region(input int n, input bit plant);
    logic [7:0] region_bytes [];
    int         len;
    int         start;
    len = sb.span();
    if (plant && n < len) n = len + $urandom_range(0, 4);
    region_bytes = new[n];
    for (int i = 0; i < n; i++)
      region_bytes[i] = ($urandom_range(0, 2) == 0) ? sb.pattern_at($urandom_range(0, len - 1))
                                                    : 8'($urandom);
    if (plant) begin
      start = $urandom_range(0, n - len);
      for (int j = 0; j < len; j++)
        if (!sb.wild_mask[j]) region_bytes[start + j] = sb.pattern_at(j);
    end
    for (int i = 0; i < n; i++) send_beat(region_bytes[i], i == n - 1);
  endtask

  initial begin
    int phase;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults after reset: one-byte pattern of zero.
    send_beat(8'h00, 1'b1);

    // Wildcard in the middle, literal 0x3F at the end, address wrap,
    // match completed by the last byte, then a region with no match.
    drain(4);
    program_scan(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FF3F_3FAA, '1, 64'h0002, 64'd3, 1'b1);
    send_beat(8'h11, 1'b0);
    send_beat(8'h22, 1'b0);
    send_beat(8'h33, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h3F, 1'b1);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h12, 1'b0);
    send_beat(8'h40, 1'b1);

    // Length zero acts as one; bytes after the first match are ignored.
    drain(4);
    program_scan(64'h1000, 64'h5A, '0, '0, '0, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h5A, 1'b1);

    // Oversize length clamps to the full width; all positions wild.
    drain(4);
    program_scan(64'h8000_0000_0000_0000, {$urandom, $urandom}, {$urandom, $urandom},
                 64'hFFFF, 64'd17, 1'b0);
    for (int i = 0; i < 16; i++) send_beat(8'($urandom), i == 15);

    // Random phases of well-formed regions with occasional oversize lengths.
    phase = 0;
    while (beats_sent < RANDOM_BYTES) begin
      pick_settings(phase);
      repeat ($urandom_range(3, 8))
        send_region(($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                : $urandom_range(1, 20),
                    $urandom_range(0, 9) < 6);
      phase++;
    end

    drain(8);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_wildcard_byte_pattern_scanner_unit OK");
    end else begin
      $display("tb_wildcard_byte_pattern_scanner_unit NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_cell.sv
hw/rtl/wildcard_byte_pattern_scanner_unit.sv
tb/tb_wildcard_byte_pattern_scanner_unit.sv
